/* design/rlt_pkg.sv */
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types and constants of the range lock table.
// ----------------------------------------------------------------------------
package rlt_pkg;

  // table depth, 2 to 16 (a slot has SLOT_W bits)
  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);

  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int START_W    = 62;
  localparam int END_W      = START_W + 1;
  localparam int STATUS_W   = 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOCK    = 2'd0,
    MODE_RECHECK = 2'd1,
    MODE_UNLOCK  = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_GRANTED  = 2'd0,
    STS_WAITING  = 2'd1,
    STS_RELEASED = 2'd2,
    STS_ERROR    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_LOCK,
    CMD_RECHECK,
    CMD_UNLOCK,
    CMD_ERROR
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [IDX_W-1:0]   idx;
    logic [START_W-1:0] range_start;
    logic [END_W-1:0]   range_end;
    logic               is_shared;
  } cmd_t;

endpackage

/* design/rlt_if.sv */
// ----------------------------------------------------------------------------
// rlt_req_if / rlt_rsp_if
// Valid/ready channels for lock requests and lock results.
// ----------------------------------------------------------------------------
interface rlt_req_if;
  logic                          valid;
  logic                          ready;
  logic [rlt_pkg::MODE_W-1:0]    mode;
  logic [rlt_pkg::SLOT_W-1:0]    slot;
  logic [rlt_pkg::START_W-1:0]   range_start;
  logic [rlt_pkg::START_W-1:0]   range_length;
  logic                          is_shared;

  modport source (output valid, mode, slot, range_start, range_length, is_shared,
                  input ready);
  modport sink (input valid, mode, slot, range_start, range_length, is_shared,
                output ready);
endinterface

interface rlt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rlt_pkg::STATUS_W-1:0]  status;
  logic                          wake;

  modport source (output valid, status, wake, input ready);
  modport sink (input valid, status, wake, output ready);
endinterface

/* design/rlt_front.sv */
// ----------------------------------------------------------------------------
// rlt_front
// Request decode: classifies mode and slot, computes the range end.
// ----------------------------------------------------------------------------
module rlt_front (
  rlt_req_if.sink         req_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output rlt_pkg::cmd_t   push_data_o
);

  logic slot_ok;

  assign slot_ok      = (32'(req_i.slot) < rlt_pkg::ENTRIES);
  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

  always_comb begin
    push_data_o.idx         = rlt_pkg::IDX_W'(req_i.slot);
    push_data_o.range_start = req_i.range_start;
    // exact end in one extra bit
    push_data_o.range_end   = rlt_pkg::END_W'(req_i.range_start) +
                              rlt_pkg::END_W'(req_i.range_length);
    push_data_o.is_shared   = req_i.is_shared;
    push_data_o.kind        = rlt_pkg::CMD_ERROR;
    if (slot_ok) begin
      unique case (req_i.mode)
        rlt_pkg::MODE_LOCK:    push_data_o.kind = rlt_pkg::CMD_LOCK;
        rlt_pkg::MODE_RECHECK: push_data_o.kind = rlt_pkg::CMD_RECHECK;
        rlt_pkg::MODE_UNLOCK:  push_data_o.kind = rlt_pkg::CMD_UNLOCK;
        default:               push_data_o.kind = rlt_pkg::CMD_ERROR;
      endcase
    end
  end

endmodule

/* design/rlt_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// rlt_cmd_fifo
// Short command queue between request decode and table execution.
// ----------------------------------------------------------------------------
module rlt_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rlt_pkg::cmd_t  push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rlt_pkg::cmd_t  pop_data_o
);

  rlt_pkg::cmd_t                    mem_q [rlt_pkg::FIFO_DEPTH];
  logic [rlt_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [rlt_pkg::FIFO_CNT_W-1:0]   cnt_q;
  logic                             do_push, do_pop;

  assign push_ready_o = (cnt_q != rlt_pkg::FIFO_CNT_W'(rlt_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  function automatic logic [rlt_pkg::FIFO_PTR_W-1:0] ptr_inc(
    input logic [rlt_pkg::FIFO_PTR_W-1:0] p);
    if (p == rlt_pkg::FIFO_PTR_W'(rlt_pkg::FIFO_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* design/rlt_back.sv */
// ----------------------------------------------------------------------------
// rlt_back
// Table execution: entry store, one-entry-per-cycle conflict scan, result.
// ----------------------------------------------------------------------------
module rlt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  rlt_pkg::cmd_t   cmd_i,
  rlt_rsp_if.source       rsp_o
);

  localparam int IW = rlt_pkg::IDX_W;
  localparam int N  = rlt_pkg::ENTRIES;

  // entry store, one read port with registered data
  logic [rlt_pkg::START_W-1:0] start_mem [N];
  logic [rlt_pkg::END_W-1:0]   end_mem   [N];
  logic                        shared_mem [N];
  logic [rlt_pkg::START_W-1:0] rd_start_q;
  logic [rlt_pkg::END_W-1:0]   rd_end_q;
  logic                        rd_shared_q;

  logic [N-1:0] valid_q, waiting_q, marked_q;

  rlt_pkg::state_e state_q, state_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   cmp_idx_q;
  logic            cmp_vld_q, cmp_vld_d;
  logic            conflict_q;

  logic [IW-1:0]               own_idx_q;
  logic [rlt_pkg::START_W-1:0] own_start_q;
  logic [rlt_pkg::END_W-1:0]   own_end_q;
  logic                        own_shared_q;
  logic                        is_lock_q;

  logic                        out_valid_q;
  logic [rlt_pkg::STATUS_W-1:0] out_status_q;
  logic                        out_wake_q;

  logic            out_free, cmd_pop, mem_we, res_load, res_wake;
  logic            do_lock, do_unlock, do_fin, hit;
  rlt_pkg::status_e res_status;
  logic [IW-1:0]   rd_addr;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign cmd_ready_o = cmd_pop;

  // next state and control
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmp_vld_d  = 1'b0;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = idx_q;
    res_load   = 1'b0;
    res_status = rlt_pkg::STS_ERROR;
    res_wake   = 1'b0;
    do_lock    = 1'b0;
    do_unlock  = 1'b0;
    do_fin     = 1'b0;
    unique case (state_q)
      rlt_pkg::ST_IDLE: begin
        rd_addr = cmd_i.idx;
        if (cmd_valid_i && out_free) begin
          cmd_pop = 1'b1;
          unique case (cmd_i.kind)
            rlt_pkg::CMD_LOCK: begin
              if (!valid_q[cmd_i.idx]) begin
                do_lock = 1'b1;
                mem_we  = 1'b1;
                idx_d   = '0;
                state_d = rlt_pkg::ST_SCAN;
              end else begin
                res_load = 1'b1;
              end
            end
            rlt_pkg::CMD_RECHECK: begin
              // own range comes back from the store next cycle
              if (valid_q[cmd_i.idx] && waiting_q[cmd_i.idx]) begin
                state_d = rlt_pkg::ST_LOAD;
              end else begin
                res_load = 1'b1;
              end
            end
            rlt_pkg::CMD_UNLOCK: begin
              res_load = 1'b1;
              if (valid_q[cmd_i.idx]) begin
                do_unlock  = 1'b1;
                res_status = rlt_pkg::STS_RELEASED;
                res_wake   = marked_q[cmd_i.idx];
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      rlt_pkg::ST_LOAD: begin
        idx_d   = '0;
        state_d = rlt_pkg::ST_SCAN;
      end
      rlt_pkg::ST_SCAN: begin
        cmp_vld_d = 1'b1;
        if (idx_q == IW'(N - 1)) state_d = rlt_pkg::ST_DRAIN;
        else                     idx_d   = idx_q + 1'b1;
      end
      rlt_pkg::ST_DRAIN: state_d = rlt_pkg::ST_FIN;
      rlt_pkg::ST_FIN: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = conflict_q ? rlt_pkg::STS_WAITING : rlt_pkg::STS_GRANTED;
          do_fin     = 1'b1;
          state_d    = rlt_pkg::ST_IDLE;
        end
      end
      default: state_d = rlt_pkg::ST_IDLE;
    endcase
  end

  // compare stage, aligned with the registered read data
  assign hit = cmp_vld_q && (cmp_idx_q != own_idx_q) && valid_q[cmp_idx_q] &&
               (is_lock_q || !waiting_q[cmp_idx_q]) &&
               !(own_shared_q && rd_shared_q) &&
               ({1'b0, own_start_q} < rd_end_q) &&
               ({1'b0, rd_start_q} < own_end_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      start_mem[cmd_i.idx]  <= cmd_i.range_start;
      end_mem[cmd_i.idx]    <= cmd_i.range_end;
      shared_mem[cmd_i.idx] <= cmd_i.is_shared;
    end
    rd_start_q  <= start_mem[rd_addr];
    rd_end_q    <= end_mem[rd_addr];
    rd_shared_q <= shared_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
    if (cmd_pop) begin
      own_idx_q    <= cmd_i.idx;
      own_start_q  <= cmd_i.range_start;
      own_end_q    <= cmd_i.range_end;
      own_shared_q <= cmd_i.is_shared;
      is_lock_q    <= (cmd_i.kind == rlt_pkg::CMD_LOCK);
    end else if (state_q == rlt_pkg::ST_LOAD) begin
      own_start_q  <= rd_start_q;
      own_end_q    <= rd_end_q;
      own_shared_q <= rd_shared_q;
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_wake_q   <= res_wake;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlt_pkg::ST_IDLE;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      conflict_q  <= 1'b0;
      valid_q     <= '0;
      waiting_q   <= '0;
      marked_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      if (cmd_pop)  conflict_q <= 1'b0;
      else if (hit) conflict_q <= 1'b1;
      if (do_lock) begin
        valid_q[cmd_i.idx]  <= 1'b1;
        marked_q[cmd_i.idx] <= 1'b0;
      end
      if (do_unlock) begin
        valid_q[cmd_i.idx]   <= 1'b0;
        waiting_q[cmd_i.idx] <= 1'b0;
        marked_q[cmd_i.idx]  <= 1'b0;
      end
      if (hit)    marked_q[cmp_idx_q]  <= 1'b1;
      // lock: waits on any conflict; recheck: granted when none left
      if (do_fin) waiting_q[own_idx_q] <= conflict_q;
      if (res_load)         out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.wake   = out_wake_q;

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> state_q == rlt_pkg::ST_IDLE)
    else $error("command taken outside idle");

  a_waiting_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (waiting_q & ~valid_q) == '0)
    else $error("waiting flag on free entry");

  a_marked_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (marked_q & ~valid_q) == '0)
    else $error("conflict mark on free entry");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || rsp_o.ready))
    else $error("result register overwritten");

  a_drain_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rlt_pkg::ST_DRAIN |=> state_q == rlt_pkg::ST_FIN && !cmp_vld_q)
    else $error("scan did not close");

endmodule

/* design/range_lock_table_core.sv */
// ----------------------------------------------------------------------------
// range_lock_table_core
// Shared/exclusive byte-range lock table with per-slot lock records.
// ----------------------------------------------------------------------------
// A request is decoded on entry and placed in a two-deep command queue, so
// new requests are taken while the table works or a result waits. Recheck
// first reads its own range back, since the range store has one read port;
// lock and recheck then scan the table, reading one entry per cycle, and
// the drain state finishes the compare before the fin state writes the
// result. Unlock and misused slots are answered from the idle state without
// a scan. Entry ranges are not cleared at reset; only the valid, waiting and
// mark flags are, so the block is ready right after reset.
module range_lock_table_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  rlt_req_if.sink   req_i,
  rlt_rsp_if.source rsp_o
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  rlt_pkg::cmd_t push_data, pop_data;

  rlt_front u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rlt_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rlt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .rsp_o       (rsp_o)
  );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_lock_table_core. A directed walk covers
// misuse errors, the grant/wait/recheck/release cycle and range extremes.
// It is followed by mostly well-formed random lock traffic with some noise.
// A scoreboard predicts each result and compares it with the response channel.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import rlt_pkg::*;

  localparam logic [MODE_W-1:0]  MODE_BAD     = 2'd3;  // undefined opcode
  localparam logic [START_W-1:0] SPAN_MAX     = '1;
  localparam int                 RANDOM_ITEMS = 1200;
  localparam int                 DRAIN_CYCLES = 40;
  localparam int                 REPORT_MAX   = 10;

  typedef enum int {
    PICK_FREE,
    PICK_WAITING,
    PICK_HELD
  } slot_pick_e;

  typedef struct {
    status_e status;
    logic    wake;
  } lock_outcome_t;

  // Tracks the lock table and holds the results still owed by the block.
  class lock_scoreboard;
    bit                 valid_q   [ENTRIES];
    logic [START_W-1:0] start_q   [ENTRIES];
    logic [START_W-1:0] len_q     [ENTRIES];
    bit                 shared_q  [ENTRIES];
    bit                 waiting_q [ENTRIES];
    bit                 marked_q  [ENTRIES];
    lock_outcome_t      owed_q[$];
    int                 mismatches;

    function bit clashes(int a, int b);
      logic [END_W-1:0] end_a;
      logic [END_W-1:0] end_b;
      if (shared_q[a] && shared_q[b]) return 1'b0;
      end_a = {1'b0, start_q[a]} + {1'b0, len_q[a]};
      end_b = {1'b0, start_q[b]} + {1'b0, len_q[b]};
      return ({1'b0, start_q[a]} < end_b) && ({1'b0, start_q[b]} < end_a);
    endfunction

    // Accepted request: update the table and queue the result it owes.
    function void note_request(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                               logic [START_W-1:0] rs, logic [START_W-1:0] rl,
                               logic sh);
      lock_outcome_t res;
      int            s;
      int            j;
      bit            hit;
      res.status = STS_ERROR;
      res.wake   = 1'b0;
      hit        = 1'b0;
      s          = int'(slot);
      if (s < ENTRIES) begin
        if (mode == MODE_LOCK && !valid_q[s]) begin
          valid_q[s]  = 1'b1;
          start_q[s]  = rs;
          len_q[s]    = rl;
          shared_q[s] = sh;
          marked_q[s] = 1'b0;
          // waiting entries count as holders at lock time
          for (j = 0; j < ENTRIES; j++) begin
            if (j != s && valid_q[j] && clashes(s, j)) begin
              marked_q[j] = 1'b1;
              hit         = 1'b1;
            end
          end
          waiting_q[s] = hit;
          res.status   = hit ? STS_WAITING : STS_GRANTED;
        end else if (mode == MODE_RECHECK && valid_q[s] && waiting_q[s]) begin
          for (j = 0; j < ENTRIES; j++) begin
            if (j != s && valid_q[j] && !waiting_q[j] && clashes(s, j)) begin
              marked_q[j] = 1'b1;
              hit         = 1'b1;
            end
          end
          if (!hit) waiting_q[s] = 1'b0;
          res.status = hit ? STS_WAITING : STS_GRANTED;
        end else if (mode == MODE_UNLOCK && valid_q[s]) begin
          res.wake     = marked_q[s];
          valid_q[s]   = 1'b0;
          waiting_q[s] = 1'b0;
          marked_q[s]  = 1'b0;
          res.status   = STS_RELEASED;
        end
      end
      owed_q.push_back(res);
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic wake);
      lock_outcome_t want;
      if (owed_q.size() == 0) begin
        flag_mismatch($sformatf("result with none owed: status %0d wake %0d",
                                status, wake));
        return;
      end
      want = owed_q.pop_front();
      if (status !== want.status || wake !== want.wake)
        flag_mismatch($sformatf("status %0d wake %0d, expected status %0d wake %0d",
                                status, wake, want.status, want.wake));
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    function int held_count();
      int j;
      int n;
      n = 0;
      for (j = 0; j < ENTRIES; j++) if (valid_q[j]) n++;
      return n;
    endfunction

    // Random slot in the wanted condition, or -1 if there is none.
    function int pick_slot(slot_pick_e want);
      int cand[$];
      int j;
      for (j = 0; j < ENTRIES; j++) begin
        case (want)
          PICK_FREE:    if (!valid_q[j]) cand.push_back(j);
          PICK_WAITING: if (valid_q[j] && waiting_q[j]) cand.push_back(j);
          default:      if (valid_q[j]) cand.push_back(j);
        endcase
      end
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   steady;  // no idling on either side while set

  rlt_req_if req_if ();
  rlt_rsp_if rsp_if ();

  lock_scoreboard sb;

  range_lock_table_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void make_range(output logic [START_W-1:0] st,
                                     output logic [START_W-1:0] ln);
    logic [63:0] raw;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      raw = {$urandom, $urandom};
      st  = raw[START_W-1:0];
      raw = {$urandom, $urandom};
      ln  = raw[START_W-1:0];
    end else if (r < 13) begin
      // near the top of the offset space, ends may need the extra bit
      st = SPAN_MAX - START_W'($urandom_range(0, 40));
      ln = (r < 11) ? SPAN_MAX - START_W'($urandom_range(0, 40))
                    : START_W'($urandom_range(1, 64));
    end else begin
      st = START_W'($urandom_range(0, 255));
      ln = START_W'($urandom_range(1, 48));
    end
    if (ln == '0) ln = START_W'(1);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic issue(logic [MODE_W-1:0] m, logic [SLOT_W-1:0] s,
                       logic [START_W-1:0] st, logic [START_W-1:0] ln, logic sh);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.mode         <= m;
    req_if.slot         <= s;
    req_if.range_start  <= st;
    req_if.range_length <= ln;
    req_if.is_shared    <= sh;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(m, s, st, ln, sh);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  // Response side: random stalls, checks every transfer.
  initial begin : rsp_side
    int stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.status, rsp_if.wake);
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : run_limit
    #4000000;
    $display("tb: failure");
    $finish;
  end

  initial begin : req_side
    int                 n;
    int                 r;
    int                 pick;
    logic [MODE_W-1:0]  m;
    logic [SLOT_W-1:0]  s;
    logic [START_W-1:0] st;
    logic [START_W-1:0] ln;
    logic               sh;

    sb                  = new();
    steady              = 1'b0;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_LOCK;
    req_if.slot         = '0;
    req_if.range_start  = '0;
    req_if.range_length = '0;
    req_if.is_shared    = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // misuse on an empty table
    issue(MODE_UNLOCK, 0, '0, '0, 1'b0);
    issue(MODE_RECHECK, 0, '0, '0, 1'b0);
    issue(MODE_BAD, 0, '0, '0, 1'b0);
    issue(MODE_LOCK, 0, '0, 1, 1'b0);
    issue(MODE_LOCK, 0, 5, 5, 1'b1);         // slot already held
    issue(MODE_RECHECK, 0, '0, '0, 1'b0);    // granted, not waiting
    issue(MODE_LOCK, 1, 1, 1, 1'b0);         // touches slot 0, no overlap
    issue(MODE_LOCK, 2, '0, SPAN_MAX, 1'b0);
    // conflicts with the waiting entry above: still counts at lock time
    issue(MODE_LOCK, 3, SPAN_MAX - START_W'(1), SPAN_MAX, 1'b1);
    issue(MODE_RECHECK, 2, '0, '0, 1'b0);
    issue(MODE_UNLOCK, 0, '0, '0, 1'b0);
    issue(MODE_UNLOCK, 1, '0, '0, 1'b0);
    issue(MODE_RECHECK, 3, '0, '0, 1'b0);    // only waiting neighbors left
    issue(MODE_RECHECK, 2, '0, '0, 1'b0);
    issue(MODE_UNLOCK, 2, '0, '0, 1'b0);     // drop a waiting entry
    issue(MODE_UNLOCK, 3, '0, '0, 1'b0);
    issue(MODE_LOCK, 4, 100, 10, 1'b1);
    issue(MODE_LOCK, 5, 105, 10, 1'b1);      // shared with shared
    issue(MODE_LOCK, 6, 109, 1, 1'b0);
    issue(MODE_LOCK, 15, {31{2'b10}}, {31{2'b01}}, 1'b1);
    issue(MODE_UNLOCK, 4, '0, '0, 1'b0);
    issue(MODE_UNLOCK, 5, '0, '0, 1'b0);
    issue(MODE_RECHECK, 6, '0, '0, 1'b0);
    issue(MODE_UNLOCK, 6, '0, '0, 1'b0);
    issue(MODE_UNLOCK, 15, '0, '0, 1'b0);
    wait_for_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) wait_for_results();
      r  = $urandom_range(0, 99);
      sh = 1'($urandom_range(0, 1));
      make_range(st, ln);
      if (r < 12) begin
        // noise: any opcode on any slot
        m = MODE_W'($urandom_range(0, 3));
        s = SLOT_W'($urandom_range(0, 15));
      end else begin
        pick = -1;
        m    = MODE_LOCK;
        if (r < 35) begin
          pick = sb.pick_slot(PICK_WAITING);
          m    = MODE_RECHECK;
        end
        if (pick < 0 && (r < 75 || sb.pick_slot(PICK_HELD) < 0) &&
            sb.held_count() < 10) begin
          pick = sb.pick_slot(PICK_FREE);
          m    = MODE_LOCK;
        end
        if (pick < 0) begin
          pick = sb.pick_slot(PICK_HELD);
          m    = MODE_UNLOCK;
        end
        s = SLOT_W'(pick);
      end
      issue(m, s, st, ln, sh);
    end
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
design/rlt_pkg.sv
design/rlt_if.sv
design/rlt_front.sv
design/rlt_cmd_fifo.sv
design/rlt_back.sv
design/range_lock_table_core.sv
sim/tb_top.sv
